// File: src/lkv_pkg.sv
// Shared types and constants for the linear key/value table.
// Used by lkv_cell, lkv_chain and linear_key_value_table; depends on nothing.
package lkv_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int TYPE_W      = 2;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUT    = 2'd0,
      REQ_GET    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Broadcast control from the controller to every cell of the chain.
   typedef struct packed {
      logic             start;
      logic             search;
      logic             remove;
      logic             put;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } lkv_ctl_type;

endpackage

// File: src/linear_key_value_table.sv
// Linear key/value table: insertion-ordered, duplicates allowed, bounded depth.
// Put and the unused code go straight to the hold state; get and remove first let
// a token walk the cell chain one slot per cycle. The result is loaded in the hold
// state once the output is free, and the next item is accepted only back in idle.
// Reset clears the entry count and control state; stored entries are not cleared.
// Depends on lkv_pkg and lkv_chain.
module linear_key_value_table #(
   parameter int TABLE_DEPTH = lkv_pkg::TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lkv_pkg::TYPE_W-1:0]            req_type,
   input  logic signed [lkv_pkg::KEY_W-1:0]      req_key,
   input  logic signed [lkv_pkg::VAL_W-1:0]      req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lkv_pkg::VAL_W-1:0]      rsp_read_value,
   output logic                                  rsp_hit,
   output logic                                  rsp_status,
   output logic [lkv_pkg::COUNT_OUT_W-1:0]       rsp_entry_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   lkv_pkg::state_type         state_ff;
   lkv_pkg::state_type         state_in;
   lkv_pkg::req_kind_type      req_kind;
   lkv_pkg::req_kind_type      kind_ff;
   lkv_pkg::lkv_ctl_type       ctl;
   logic [lkv_pkg::KEY_W-1:0]  key_ff;
   logic                       first_ff;
   logic [CW-1:0]              count_ff;
   logic                       full;
   logic                       accept;
   logic                       scan_start;
   logic                       load;
   logic                       scan_done;
   logic                       scan_found;
   logic [lkv_pkg::VAL_W-1:0]  scan_value;
   logic [lkv_pkg::VAL_W-1:0]  pend_value_ff;
   logic                       pend_hit_ff;
   logic                       pend_status_ff;
   logic                       rsp_valid_ff;
   logic [lkv_pkg::VAL_W-1:0]  rsp_value_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_status_ff;
   logic [lkv_pkg::COUNT_OUT_W-1:0] rsp_count_ff;
   logic [CW+lkv_pkg::COUNT_OUT_W-1:0] count_ext;

   assign req_kind  = lkv_pkg::req_kind_type'(req_type);
   assign full      = count_ff == CW'(TABLE_DEPTH);
   assign accept    = req_valid & req_ready;
   assign count_ext = {{lkv_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == lkv_pkg::REQ_GET || req_kind == lkv_pkg::REQ_REMOVE) begin
                  state_in = lkv_pkg::ST_SCAN;
               end else begin
                  state_in = lkv_pkg::ST_HOLD;
               end
            end
         end
         lkv_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = lkv_pkg::ST_HOLD;
            end
         end
         lkv_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = lkv_pkg::ST_IDLE;
            end
         end
         default: state_in = lkv_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready  = 1'b0;
      scan_start = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: req_ready  = 1'b1;
         lkv_pkg::ST_SCAN: scan_start = first_ff;
         lkv_pkg::ST_HOLD: load       = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      ctl.start  = scan_start;
      ctl.search = kind_ff == lkv_pkg::REQ_GET || kind_ff == lkv_pkg::REQ_REMOVE;
      ctl.remove = kind_ff == lkv_pkg::REQ_REMOVE;
      ctl.put    = accept && req_kind == lkv_pkg::REQ_PUT && !full;
      ctl.key    = (state_ff == lkv_pkg::ST_IDLE) ? $unsigned(req_key) : key_ff;
      ctl.value  = $unsigned(req_value);
   end

   lkv_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CW          (CW)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .count       (count_ff),
      .done        (scan_done),
      .found       (scan_found),
      .found_value (scan_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         first_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= lkv_pkg::REQ_UNUSED;
      end else begin
         state_ff <= state_in;
         first_ff <= accept;
         if (accept) begin
            kind_ff <= req_kind;
         end
         if (ctl.put) begin
            count_ff <= count_ff + CW'(1);
         end else if (state_ff == lkv_pkg::ST_SCAN && scan_done && ctl.remove && scan_found) begin
            count_ff <= count_ff - CW'(1);
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff         <= $unsigned(req_key);
         pend_value_ff  <= '0;
         pend_hit_ff    <= 1'b0;
         pend_status_ff <= (req_kind == lkv_pkg::REQ_PUT) && full;
      end else if (state_ff == lkv_pkg::ST_SCAN && scan_done) begin
         pend_value_ff  <= (ctl.remove || !scan_found) ? '0 : scan_value;
         pend_hit_ff    <= scan_found;
         pend_status_ff <= 1'b0;
      end
      if (load) begin
         rsp_value_ff  <= pend_value_ff;
         rsp_hit_ff    <= pend_hit_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_count_ff  <= count_ext[lkv_pkg::COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// File: src/lkv_cell.sv
// One slot of the table: a stored key/value pair plus the scan token stage.
// Depends on lkv_pkg.
module lkv_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lkv_pkg::lkv_ctl_type        ctl,
   input  logic [CW-1:0]               count,
   input  logic                        tok_in,
   input  logic                        found_in,
   input  logic [lkv_pkg::VAL_W-1:0]   val_in,
   input  logic [lkv_pkg::KEY_W-1:0]   nb_key,
   input  logic [lkv_pkg::VAL_W-1:0]   nb_value,
   output logic                        tok_out,
   output logic                        found_out,
   output logic [lkv_pkg::VAL_W-1:0]   val_out,
   output logic [lkv_pkg::KEY_W-1:0]   key_out,
   output logic [lkv_pkg::VAL_W-1:0]   value_out
);

   logic                       tok_ff;
   logic                       found_ff;
   logic [lkv_pkg::VAL_W-1:0]  val_ff;
   logic [lkv_pkg::KEY_W-1:0]  key_ff;
   logic [lkv_pkg::VAL_W-1:0]  value_ff;
   logic                       occupied;
   logic                       match;
   logic                       shift;
   logic                       write;

   assign occupied = CW'(IDX) < count;
   // Only the first matching slot claims the item; later slots see found_in.
   assign match    = tok_in & ctl.search & ~found_in & occupied & (key_ff == ctl.key);
   // From the removed slot onward, each slot pulls in its upper neighbor
   // before the token reaches that neighbor.
   assign shift    = tok_in & ctl.remove & (found_in | match);
   assign write    = ctl.put & (count == CW'(IDX));

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in | match;
      val_ff   <= match ? value_ff : val_in;
      if (write) begin
         key_ff   <= ctl.key;
         value_ff <= ctl.value;
      end else if (shift) begin
         key_ff   <= nb_key;
         value_ff <= nb_value;
      end
   end

   assign tok_out   = tok_ff;
   assign found_out = found_ff;
   assign val_out   = val_ff;
   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

// File: src/lkv_chain.sv
// Row of lkv_cell slots; the scan token and its result ride from slot to slot.
// Depends on lkv_pkg and lkv_cell.
module lkv_chain #(
   parameter int TABLE_DEPTH = lkv_pkg::TABLE_DEPTH,
   parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lkv_pkg::lkv_ctl_type        ctl,
   input  logic [CW-1:0]               count,
   output logic                        done,
   output logic                        found,
   output logic [lkv_pkg::VAL_W-1:0]   found_value
);

   logic                       tok_q   [TABLE_DEPTH+1];
   logic                       found_q [TABLE_DEPTH+1];
   logic [lkv_pkg::VAL_W-1:0]  val_q   [TABLE_DEPTH+1];
   logic [lkv_pkg::KEY_W-1:0]  key_q   [TABLE_DEPTH+1];
   logic [lkv_pkg::VAL_W-1:0]  value_q [TABLE_DEPTH+1];

   assign tok_q[0]             = ctl.start;
   assign found_q[0]           = 1'b0;
   assign val_q[0]             = '0;
   // Nothing lies above the top slot; what it takes in on a remove is unused.
   assign key_q[TABLE_DEPTH]   = '0;
   assign value_q[TABLE_DEPTH] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      lkv_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .count     (count),
         .tok_in    (tok_q[i]),
         .found_in  (found_q[i]),
         .val_in    (val_q[i]),
         .nb_key    (key_q[i+1]),
         .nb_value  (value_q[i+1]),
         .tok_out   (tok_q[i+1]),
         .found_out (found_q[i+1]),
         .val_out   (val_q[i+1]),
         .key_out   (key_q[i]),
         .value_out (value_q[i])
      );
   end

   assign done        = tok_q[TABLE_DEPTH];
   assign found       = found_q[TABLE_DEPTH];
   assign found_value = val_q[TABLE_DEPTH];

endmodule

// File: sim/linear_key_value_table_tb.sv
// Self-checking testbench for linear_key_value_table: put, get, remove and unused-code items
// are checked against a shadow copy of the table kept inside this file.
// Depends on lkv_pkg and the linear_key_value_table RTL.
`timescale 1ns / 1ps

module linear_key_value_table_tb;

   typedef struct {
      lkv_pkg::req_kind_type                kind;
      logic [lkv_pkg::KEY_W-1:0]            key;
      logic [lkv_pkg::VAL_W-1:0]            value;
      bit                                   drain_first;
   } table_request_type;

   typedef struct {
      logic [lkv_pkg::VAL_W-1:0]            read_value;
      logic                                 hit;
      logic                                 status;
      logic [lkv_pkg::COUNT_OUT_W-1:0]      entry_count;
   } table_response_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [lkv_pkg::TYPE_W-1:0]            req_type = lkv_pkg::REQ_PUT;
   logic signed [lkv_pkg::KEY_W-1:0]      req_key = '0;
   logic signed [lkv_pkg::VAL_W-1:0]      req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [lkv_pkg::VAL_W-1:0]      rsp_read_value;
   logic                                  rsp_hit;
   logic                                  rsp_status;
   logic [lkv_pkg::COUNT_OUT_W-1:0]       rsp_entry_count;

   table_request_type  request_backlog[$];
   table_response_type expected_responses[$];

   logic [lkv_pkg::KEY_W-1:0] shadow_keys   [lkv_pkg::TABLE_DEPTH];
   logic [lkv_pkg::VAL_W-1:0] shadow_values [lkv_pkg::TABLE_DEPTH];
   int                        shadow_count = 0;

   logic [lkv_pkg::KEY_W-1:0] key_pool [8];
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int issue_count = 0;
   int accept_count = 0;
   int mismatch_count = 0;

   linear_key_value_table u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_hit         (rsp_hit),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one item to the shadow table and returns the result it must produce.
   function automatic table_response_type apply_table_request(
         input lkv_pkg::req_kind_type kind,
         input logic [lkv_pkg::KEY_W-1:0] key,
         input logic [lkv_pkg::VAL_W-1:0] value);
      table_response_type r;
      int pos;
      int i;
      r = '{read_value: '0, hit: 1'b0, status: 1'b0, entry_count: '0};
      pos = -1;
      for (i = 0; i < shadow_count; i++) begin
         if (pos < 0 && shadow_keys[i] == key) pos = i;
      end
      case (kind)
         lkv_pkg::REQ_PUT: begin
            if (shadow_count < lkv_pkg::TABLE_DEPTH) begin
               shadow_keys[shadow_count]   = key;
               shadow_values[shadow_count] = value;
               shadow_count++;
            end else begin
               r.status = 1'b1;
            end
         end
         lkv_pkg::REQ_GET: begin
            if (pos >= 0) begin
               r.read_value = shadow_values[pos];
               r.hit        = 1'b1;
            end
         end
         lkv_pkg::REQ_REMOVE: begin
            if (pos >= 0) begin
               for (i = pos; i + 1 < shadow_count; i++) begin
                  shadow_keys[i]   = shadow_keys[i + 1];
                  shadow_values[i] = shadow_values[i + 1];
               end
               shadow_count--;
               r.hit = 1'b1;
            end
         end
         default: ;
      endcase
      r.entry_count = lkv_pkg::COUNT_OUT_W'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic queue_request(input lkv_pkg::req_kind_type kind,
                                input logic [lkv_pkg::KEY_W-1:0] key,
                                input logic [lkv_pkg::VAL_W-1:0] value,
                                input bit drain_first);
      table_request_type item;
      item.kind        = kind;
      item.key         = key;
      item.value       = value;
      item.drain_first = drain_first;
      request_backlog.push_back(item);
   endtask

   // Random traffic in segments of 40 items. Each segment has its own put weight, so
   // the table swings between empty and full, and most keys come from a small pool
   // so that gets and removes often hit, duplicates included.
   task automatic queue_random_traffic(input int total);
      int put_pct;
      int roll;
      int sent;
      int k;
      lkv_pkg::req_kind_type kind;
      logic [lkv_pkg::KEY_W-1:0] key;
      sent = 0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      while (sent < total) begin
         put_pct = $urandom_range(75, 15);
         for (k = 4; k < 8; k++) key_pool[k] = $urandom;
         repeat (40) begin
            roll = $urandom_range(99);
            if (roll < 4) kind = lkv_pkg::REQ_UNUSED;
            else if (roll < 4 + put_pct) kind = lkv_pkg::REQ_PUT;
            else if ($urandom_range(1) == 0) kind = lkv_pkg::REQ_GET;
            else kind = lkv_pkg::REQ_REMOVE;
            if ($urandom_range(99) < 80) key = key_pool[$urandom_range(7)];
            else key = $urandom;
            queue_request(kind, key, $urandom, $urandom_range(99) == 0);
            sent++;
         end
      end
   endtask

   task automatic wait_backlog_empty;
      while (request_backlog.size() != 0) @(posedge clock);
   endtask

   // Driver: inputs change on the falling edge only.
   always @(negedge clock) begin : request_driver
      table_request_type head_item;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         if (!req_valid || accept_count == issue_count) begin
            // An item marked drain_first is held back until every result is in.
            if (request_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct &&
                !(request_backlog[0].drain_first && expected_responses.size() != 0)) begin
               head_item = request_backlog.pop_front();
               req_type  <= head_item.kind;
               req_key   <= head_item.key;
               req_value <= head_item.value;
               req_valid <= 1'b1;
               issue_count <= issue_count + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: both handshakes are sampled on the rising edge.
   always @(posedge clock) begin : response_monitor
      table_response_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected result", rsp_read_value, '0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_entry_count),
                                  32'(want.entry_count));
            end
         end
         if (req_valid && req_ready) begin
            expected_responses.push_back(
               apply_table_request(lkv_pkg::req_kind_type'(req_type), req_key, req_value));
            accept_count <= accept_count + 1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin : stimulus
      int i;
      req_idle_pct = 26;
      rsp_idle_pct = 78;

      // Misses on an empty table, then extreme keys and values with a duplicate key.
      queue_request(lkv_pkg::REQ_GET,    32'h0000_0000, 32'h1111_1111, 1'b0);
      queue_request(lkv_pkg::REQ_REMOVE, 32'h0000_0000, 32'h2222_2222, 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'h8000_0000, 32'h1234_5678, 1'b0);
      // Get and remove act on the oldest of the duplicates.
      queue_request(lkv_pkg::REQ_GET,    32'h8000_0000, 32'h0000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_request(lkv_pkg::REQ_GET,    32'h8000_0000, 32'h0000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_GET,    32'h5555_5555, 32'h0000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      // Fill the table, then one put too many.
      for (i = 0; i < 12; i++)
         queue_request(lkv_pkg::REQ_PUT, 32'hA5A5_0000 + i, ~(32'hA5A5_0000 + i), 1'b0);
      queue_request(lkv_pkg::REQ_PUT,    32'h0BAD_0BAD, 32'h0BAD_0BAD, 1'b0);
      // Remove from the middle of a full table so later entries shift down.
      queue_request(lkv_pkg::REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0);
      queue_request(lkv_pkg::REQ_GET,    32'h8000_0000, 32'h0000_0000, 1'b0);

      request_backlog.push_back('{kind: lkv_pkg::REQ_GET, key: 32'hA5A5_000B, value: '0,
                                  drain_first: 1'b1});
      queue_random_traffic(600);
      wait_backlog_empty();

      req_idle_pct = 78;
      rsp_idle_pct = 26;
      queue_request(lkv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0, 1'b1);
      queue_random_traffic(640);
      wait_backlog_empty();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_random_traffic(640);
      wait_backlog_empty();

      while (!(accept_count == issue_count && expected_responses.size() == 0))
         @(posedge clock);
      repeat (4 * lkv_pkg::TABLE_DEPTH) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
src/lkv_pkg.sv
src/lkv_cell.sv
src/lkv_chain.sv
src/linear_key_value_table.sv
sim/linear_key_value_table_tb.sv
